FILE: src/curve_peak_baseline_quantifier_defines.svh
// Assertion macros used by the checker file of the peak quantifier.
// Depends on nothing; included by bare file name.
`ifndef CURVE_PEAK_BASELINE_QUANTIFIER_DEFINES_SVH
`define CURVE_PEAK_BASELINE_QUANTIFIER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CPBQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpbq check failed");

// Next-cycle implication, disabled in reset.
`define CPBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpbq check failed");

`endif

FILE: src/cpbq_pkg.sv
// Package of the peak quantifier: sizes, command and config types, states, helpers.
// Depends on nothing.
package cpbq_pkg;

  localparam int CURVE_LENGTH = 1024;
  localparam int LOW_EDGE     = 8;
  localparam int HIGH_EDGE    = 1016;

  localparam int IDX_W  = $clog2(CURVE_LENGTH);
  localparam int SCAN_W = 13;
  localparam int S_W    = 14;
  localparam int ACC_W  = 40;
  localparam int DIVN_W = $clog2(ACC_W + 1);
  localparam int SMP_W  = 19;
  localparam int POS_W  = 10;
  localparam int AVG_W  = 27;
  localparam int EN_W   = 37;
  localparam int NUM_PEAKS = 6;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [EN_W-1:0] AREA_DEFAULT   = EN_W'(10 << 8);
  localparam logic [EN_W-1:0] HEIGHT_DEFAULT = EN_W'(1 << 8);

  typedef enum logic [2:0] {
    REG_BASELINE_MODE    = 3'd0,
    REG_BASE_START       = 3'd1,
    REG_BASE_STOP        = 3'd2,
    REG_BASE_WINDOW      = 3'd3,
    REG_SEARCH_WINDOW    = 3'd4,
    REG_INTEGRATE_WINDOW = 3'd5,
    REG_PEAK_POSITIONS   = 3'd6,
    REG_PEAK_MODES       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        baseline_mode;
    logic [9:0]  base_start;
    logic [9:0]  base_stop;
    logic [9:0]  base_window;
    logic [9:0]  search_window;
    logic [9:0]  integrate_window;
    logic [59:0] peak_positions;
    logic [11:0] peak_modes;
  } cfg_t;

  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] addr;
    logic [SMP_W-1:0] data;
    logic             start;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BL_SCAN,
    ST_AVG_SCAN,
    ST_DIV,
    ST_PK_SETUP,
    ST_PK_MAX,
    ST_PK_RD,
    ST_PK_EN,
    ST_PK_OUT
  } eng_state_e;

  function automatic logic signed [S_W-1:0] clip_lo(input logic signed [S_W-1:0] v);
    return (v < S_W'(LOW_EDGE)) ? S_W'(LOW_EDGE) : v;
  endfunction

  function automatic logic signed [S_W-1:0] clip_hi(input logic signed [S_W-1:0] v);
    return (v > S_W'(HIGH_EDGE)) ? S_W'(HIGH_EDGE) : v;
  endfunction

  function automatic logic valid_pos(input logic signed [S_W-1:0] p);
    return (p > S_W'(LOW_EDGE)) && (p < S_W'(HIGH_EDGE));
  endfunction

endpackage

FILE: src/cpbq_if.sv
// Handshake interfaces of the peak quantifier: sample input, result output, config write.
// Depends on nothing.
interface cpbq_in_if;
  logic        valid;
  logic        ready;
  logic [18:0] sample;
  logic        last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface

interface cpbq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  peak_number;
  logic [9:0]  peak_position;
  logic [18:0] peak_height;
  logic [36:0] peak_energy;
  logic [9:0]  base_position;
  logic [26:0] base_level;
  logic        last_result;
  modport source (output valid, peak_number, peak_position, peak_height, peak_energy,
                  base_position, base_level, last_result, input ready);
  modport sink (input valid, peak_number, peak_position, peak_height, peak_energy,
                base_position, base_level, last_result, output ready);
endinterface

interface cpbq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [59:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/curve_peak_baseline_quantifier.sv
// Baseline-subtracted peak quantifier. Samples are taken one per cycle into a
// four-entry command queue and written to the store; the item marked last starts
// the analysis, which scans the store through its one read port (one entry a cycle
// with registered read data), runs the divider for the baseline (40 steps and one
// to load the quotient) and emits six results.
// Input stalls only while the queue is full during an analysis. Reset is synchronous.
module curve_peak_baseline_quantifier
  import cpbq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  cpbq_in_if.sink    in_ch,
  cpbq_out_if.source out_ch,
  cpbq_cfg_if.sink   cfg_ch
);

  cfg_t cfg_r;
  cmd_t push_cmd, pop_cmd;
  logic push_valid, push_ready, pop_valid, pop_ready;

  // config writes always accepted; the user writes only while engine idle (unenforced)
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_e'(cfg_ch.index))
        REG_BASELINE_MODE:    cfg_r.baseline_mode    <= cfg_ch.data[0];
        REG_BASE_START:       cfg_r.base_start       <= cfg_ch.data[9:0];
        REG_BASE_STOP:        cfg_r.base_stop        <= cfg_ch.data[9:0];
        REG_BASE_WINDOW:      cfg_r.base_window      <= cfg_ch.data[9:0];
        REG_SEARCH_WINDOW:    cfg_r.search_window    <= cfg_ch.data[9:0];
        REG_INTEGRATE_WINDOW: cfg_r.integrate_window <= cfg_ch.data[9:0];
        REG_PEAK_POSITIONS:   cfg_r.peak_positions   <= cfg_ch.data;
        REG_PEAK_MODES:       cfg_r.peak_modes       <= cfg_ch.data[11:0];
        default:              ;
      endcase
    end
  end

  // front: count loaded samples and classify each item
  cpbq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_ch.valid),
    .item_sample (in_ch.sample),
    .item_last   (in_ch.last_sample),
    .item_ready  (in_ch.ready),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  // decouple loading from analysis
  cpbq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: store, scans and result register
  cpbq_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd_valid         (pop_valid),
    .cmd_ready         (pop_ready),
    .cmd               (pop_cmd),
    .res_valid         (out_ch.valid),
    .res_ready         (out_ch.ready),
    .res_peak_number   (out_ch.peak_number),
    .res_peak_position (out_ch.peak_position),
    .res_peak_height   (out_ch.peak_height),
    .res_peak_energy   (out_ch.peak_energy),
    .res_base_position (out_ch.base_position),
    .res_base_level    (out_ch.base_level),
    .res_last_result   (out_ch.last_result)
  );

endmodule

FILE: src/cpbq_front.sv
// Front end: tracks the load count and turns each input item into a queue command.
// Depends on cpbq_pkg.
module cpbq_front
  import cpbq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  logic [SMP_W-1:0] item_sample,
  input  logic             item_last,
  output logic             item_ready,
  output logic             push_valid,
  input  logic             push_ready,
  output cmd_t             push_cmd
);

  logic [IDX_W:0] load_count_r;
  logic [IDX_W:0] load_count_nxt;
  logic           room;

  assign room       = load_count_r < (IDX_W + 1)'(CURVE_LENGTH);
  assign item_ready = push_ready;
  assign push_valid = item_valid;

  always_comb begin
    push_cmd.wr    = room;
    push_cmd.addr  = load_count_r[IDX_W-1:0];
    push_cmd.data  = item_sample;
    push_cmd.start = item_last;
  end

  always_comb begin
    load_count_nxt = load_count_r;
    if (item_valid && push_ready) begin
      if (item_last) begin
        load_count_nxt = '0;
      end else if (room) begin
        load_count_nxt = load_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
    end else begin
      load_count_r <= load_count_nxt;
    end
  end

endmodule

FILE: src/cpbq_queue.sv
// Short command queue between the front end and the analysis engine.
// Depends on cpbq_pkg.
module cpbq_queue
  import cpbq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t               slots_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic               do_push, do_pop;

  assign push_ready = count_r != (Q_PTR_W + 1)'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (Q_PTR_W + 1)'(do_push) - (Q_PTR_W + 1)'(do_pop);
    end
  end

endmodule

FILE: src/cpbq_engine.sv
// Back end: sample store, baseline and peak scans, divider and result register.
// Depends on cpbq_pkg.
module cpbq_engine
  import cpbq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [2:0]        res_peak_number,
  output logic [POS_W-1:0]  res_peak_position,
  output logic [SMP_W-1:0]  res_peak_height,
  output logic [EN_W-1:0]   res_peak_energy,
  output logic [POS_W-1:0]  res_base_position,
  output logic [AVG_W-1:0]  res_base_level,
  output logic              res_last_result
);

  eng_state_e state_r, state_nxt;

  logic [SMP_W-1:0] mem [CURVE_LENGTH];
  logic [SMP_W-1:0] rdata_r;

  logic [2:0]        k_r, k_nxt;
  logic [SCAN_W-1:0] i_r, i_nxt, hi_r, hi_nxt;
  logic              rv_r, rv_nxt;
  logic [SCAN_W-1:0] ridx_r, ridx_nxt;
  logic              first_r, first_nxt;
  logic [SCAN_W-1:0] best_idx_r, best_idx_nxt;
  logic [SMP_W-1:0]  best_val_r, best_val_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [SCAN_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0]  base_idx_r, base_idx_nxt;
  logic [AVG_W-1:0]  avg_r, avg_nxt;
  logic [ACC_W-1:0]  dq_r, dq_nxt;
  logic [SCAN_W:0]   drem_r, drem_nxt;
  logic [DIVN_W-1:0] dn_r, dn_nxt;
  logic [SCAN_W-1:0] pos_r, pos_nxt;
  logic [SMP_W-1:0]  h_r, h_nxt;
  logic [EN_W-1:0]   e_r, e_nxt;
  logic              out_v_r, out_v_nxt;
  logic [2:0]        o_num_r;
  logic [POS_W-1:0]  o_pos_r, o_bpos_r;
  logic [SMP_W-1:0]  o_h_r;
  logic [EN_W-1:0]   o_e_r;
  logic [AVG_W-1:0]  o_avg_r;
  logic              o_last_r;

  logic              scanning, issue, scan_done;
  logic [SMP_W-1:0]  rval;
  logic              slot_free, out_load;
  logic signed [S_W-1:0] s_start, s_stop, s_lo_b, s_hi_b, s_best, s_pos, s_nom;
  logic signed [S_W-1:0] bwin, bhalf, shalf, ihalf;
  logic              bl_ok, pk_used, pk_height, nom_ok, pos_ok;
  logic [SCAN_W-1:0] w0_hi, w1_lo, w1_hi, pk_lo, pk_hi, ar_lo, ar_hi;
  logic [ACC_W-1:0]  ab_val, ab_best;
  logic [SCAN_W:0]   rem_sh;
  logic              rem_ge;
  logic              mem_we;

  function automatic logic [ACC_W-1:0] above(input logic [SMP_W-1:0] v,
                                             input logic [AVG_W-1:0] b);
    logic [ACC_W-1:0] sv;
    sv = ACC_W'(v) << 8;
    return (sv > ACC_W'(b)) ? sv - ACC_W'(b) : '0;
  endfunction

  // store and registered read port
  assign mem_we = (state_r == ST_IDLE) && cmd_valid && cmd.wr;
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.addr] <= cmd.data;
    end
    rdata_r <= mem[i_r[IDX_W-1:0]];
  end

  assign rval = (ridx_r >= SCAN_W'(CURVE_LENGTH)) ? '0 : rdata_r;

  assign scanning  = (state_r == ST_BL_SCAN) || (state_r == ST_AVG_SCAN) ||
                     (state_r == ST_PK_MAX) || (state_r == ST_PK_RD) || (state_r == ST_PK_EN);
  assign issue     = scanning && (i_r < hi_r);
  assign scan_done = scanning && !issue && !rv_r;
  assign cmd_ready = state_r == ST_IDLE;
  assign slot_free = !out_v_r || res_ready;
  assign out_load  = (state_r == ST_PK_OUT) && slot_free;

  // window bounds
  always_comb begin
    s_start = S_W'(cfg.base_start);
    s_stop  = S_W'(cfg.base_stop);
    s_lo_b  = (s_start > s_stop) ? s_stop : s_start;
    s_hi_b  = (s_start > s_stop) ? s_start : s_stop;
    bwin    = S_W'(cfg.base_window);
    bhalf   = S_W'(cfg.base_window[9:1]);
    shalf   = S_W'(cfg.search_window[9:1]);
    ihalf   = S_W'(cfg.integrate_window[9:1]);
    s_best  = S_W'(best_idx_r);
    s_pos   = S_W'(pos_r);
    s_nom   = S_W'(cfg.peak_positions[POS_W*k_r +: POS_W]);
    bl_ok   = (s_lo_b > S_W'(LOW_EDGE)) && (s_hi_b < S_W'(HIGH_EDGE));
    pk_used   = cfg.peak_modes[k_r];
    pk_height = cfg.peak_modes[NUM_PEAKS + 32'(k_r)];
    nom_ok  = valid_pos(s_nom);
    pos_ok  = valid_pos(s_pos);
    w0_hi   = SCAN_W'(clip_hi(s_start + bwin));
    w1_lo   = SCAN_W'(clip_lo(s_best - bhalf));
    w1_hi   = SCAN_W'(clip_hi(s_best + bhalf));
    pk_lo   = SCAN_W'(clip_lo(s_nom - shalf));
    pk_hi   = SCAN_W'(clip_hi(s_nom + shalf));
    ar_lo   = SCAN_W'(clip_lo(s_pos - ihalf));
    ar_hi   = SCAN_W'(clip_hi(s_pos + ihalf));
    ab_val  = above(rval, avg_r);
    ab_best = above(best_val_r, avg_r);
    rem_sh  = {drem_r[SCAN_W-1:0], dq_r[ACC_W-1]};
    rem_ge  = rem_sh >= (SCAN_W + 1)'(cnt_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.start) begin
          if (!cfg.baseline_mode) begin
            state_nxt = valid_pos(s_start) ? ST_AVG_SCAN : ST_PK_SETUP;
          end else begin
            state_nxt = bl_ok ? ST_BL_SCAN : ST_PK_SETUP;
          end
        end
      end
      ST_BL_SCAN:  if (scan_done) state_nxt = ST_AVG_SCAN;
      ST_AVG_SCAN: if (scan_done) state_nxt = (cnt_r == '0) ? ST_PK_SETUP : ST_DIV;
      ST_DIV:      if (dn_r == '0) state_nxt = ST_PK_SETUP;
      ST_PK_SETUP: begin
        if (!pk_used) begin
          state_nxt = ST_PK_OUT;
        end else begin
          state_nxt = nom_ok ? ST_PK_MAX : ST_PK_RD;
        end
      end
      ST_PK_MAX:   if (scan_done) state_nxt = ST_PK_RD;
      ST_PK_RD: begin
        if (scan_done) begin
          state_nxt = (pos_ok && !pk_height) ? ST_PK_EN : ST_PK_OUT;
        end
      end
      ST_PK_EN:    if (scan_done) state_nxt = ST_PK_OUT;
      ST_PK_OUT: begin
        if (slot_free) begin
          state_nxt = (k_r == 3'(NUM_PEAKS - 1)) ? ST_IDLE : ST_PK_SETUP;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    k_nxt = k_r;  i_nxt = i_r;  hi_nxt = hi_r;
    rv_nxt = issue;  ridx_nxt = i_r;
    first_nxt = first_r;  best_idx_nxt = best_idx_r;  best_val_nxt = best_val_r;
    acc_nxt = acc_r;  cnt_nxt = cnt_r;  base_idx_nxt = base_idx_r;  avg_nxt = avg_r;
    dq_nxt = dq_r;  drem_nxt = drem_r;  dn_nxt = dn_r;
    pos_nxt = pos_r;  h_nxt = h_r;  e_nxt = e_r;
    out_v_nxt = out_v_r && !res_ready;
    if (issue) begin
      i_nxt = i_r + 1'b1;
    end
    // consume read data
    if (rv_r) begin
      first_nxt = 1'b0;
      unique case (state_r)
        ST_BL_SCAN: begin
          if (first_r || rval < best_val_r) begin
            best_val_nxt = rval;
            best_idx_nxt = ridx_r;
          end
        end
        ST_PK_MAX: begin
          if (first_r || rval > best_val_r) begin
            best_val_nxt = rval;
            best_idx_nxt = ridx_r;
          end
        end
        ST_PK_RD:    best_val_nxt = rval;
        ST_AVG_SCAN: begin
          acc_nxt = acc_r + ACC_W'(rval);
          cnt_nxt = cnt_r + 1'b1;
        end
        ST_PK_EN:    acc_nxt = acc_r + ab_val;
        default:     ;
      endcase
    end
    unique case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        first_nxt = 1'b1;
        acc_nxt = '0;
        cnt_nxt = '0;
        if (cmd_valid && cmd.start) begin
          if (!cfg.baseline_mode) begin
            base_idx_nxt = cfg.base_start;
            avg_nxt = '0;
            i_nxt = SCAN_W'(cfg.base_start);
            hi_nxt = w0_hi;
          end else begin
            base_idx_nxt = '0;
            avg_nxt = '0;
            i_nxt = SCAN_W'(s_lo_b);
            hi_nxt = SCAN_W'(s_hi_b) + 1'b1;
          end
        end
      end
      ST_BL_SCAN: begin
        if (scan_done) begin
          base_idx_nxt = best_idx_r[POS_W-1:0];
          i_nxt = w1_lo;
          hi_nxt = w1_hi;
        end
      end
      ST_AVG_SCAN: begin
        if (scan_done) begin
          dq_nxt = acc_r << 8;
          drem_nxt = '0;
          dn_nxt = DIVN_W'(ACC_W);
        end
      end
      ST_DIV: begin
        if (dn_r != '0) begin
          drem_nxt = rem_ge ? rem_sh - (SCAN_W + 1)'(cnt_r) : rem_sh;
          dq_nxt = {dq_r[ACC_W-2:0], rem_ge};
          dn_nxt = dn_r - 1'b1;
        end else begin
          avg_nxt = dq_r[AVG_W-1:0];
        end
      end
      ST_PK_SETUP: begin
        first_nxt = 1'b1;
        acc_nxt = '0;
        if (!pk_used) begin
          pos_nxt = '0;
          h_nxt = '0;
          e_nxt = '0;
        end else if (nom_ok) begin
          i_nxt = pk_lo;
          hi_nxt = pk_hi;
          best_idx_nxt = pk_lo;
        end else begin
          pos_nxt = '0;
          i_nxt = '0;
          hi_nxt = SCAN_W'(1);
        end
      end
      ST_PK_MAX: begin
        if (scan_done) begin
          pos_nxt = best_idx_r;
          i_nxt = best_idx_r;
          hi_nxt = best_idx_r + 1'b1;
        end
      end
      ST_PK_RD: begin
        if (scan_done) begin
          h_nxt = best_val_r;
          if (!pos_ok) begin
            e_nxt = '0;
          end else if (pk_height) begin
            e_nxt = (ab_best == '0) ? HEIGHT_DEFAULT : EN_W'(ab_best);
          end else begin
            i_nxt = ar_lo;
            hi_nxt = ar_hi;
            acc_nxt = '0;
          end
        end
      end
      ST_PK_EN: begin
        if (scan_done) begin
          e_nxt = (acc_r == '0) ? AREA_DEFAULT : EN_W'(acc_r);
        end
      end
      ST_PK_OUT: begin
        if (slot_free) begin
          out_v_nxt = 1'b1;
          k_nxt = k_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rv_r       <= 1'b0;
      out_v_r    <= 1'b0;
      base_idx_r <= '0;
      avg_r      <= '0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      rv_r       <= rv_nxt;
      out_v_r    <= out_v_nxt;
      base_idx_r <= base_idx_nxt;
      avg_r      <= avg_nxt;
      k_r        <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;  hi_r <= hi_nxt;  ridx_r <= ridx_nxt;  first_r <= first_nxt;
    best_idx_r <= best_idx_nxt;  best_val_r <= best_val_nxt;
    acc_r <= acc_nxt;  cnt_r <= cnt_nxt;
    dq_r <= dq_nxt;  drem_r <= drem_nxt;  dn_r <= dn_nxt;
    pos_r <= pos_nxt;  h_r <= h_nxt;  e_r <= e_nxt;
    if (out_load) begin
      o_num_r  <= k_r;
      o_pos_r  <= pos_r[POS_W-1:0];
      o_h_r    <= h_r;
      o_e_r    <= e_r;
      o_bpos_r <= base_idx_r;
      o_avg_r  <= avg_r;
      o_last_r <= k_r == 3'(NUM_PEAKS - 1);
    end
  end

  assign res_valid         = out_v_r;
  assign res_peak_number   = o_num_r;
  assign res_peak_position = o_pos_r;
  assign res_peak_height   = o_h_r;
  assign res_peak_energy   = o_e_r;
  assign res_base_position = o_bpos_r;
  assign res_base_level    = o_avg_r;
  assign res_last_result   = o_last_r;

endmodule

FILE: src/cpbq_checker.sv
// Port-level checks for the peak quantifier, bound to its top level.
// Depends on curve_peak_baseline_quantifier_defines.svh.
`include "curve_peak_baseline_quantifier_defines.svh"

module cpbq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_peak_number,
  input logic [9:0]  out_peak_position,
  input logic [36:0] out_peak_energy,
  input logic        out_last_result
);

  `CPBQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CPBQ_ASSERT_NOW(a_num_range, clk, rst_n, out_valid, out_peak_number <= 3'd5)
  `CPBQ_ASSERT_NOW(a_last_sixth, clk, rst_n, out_valid, out_last_result == (out_peak_number == 3'd5))
  `CPBQ_ASSERT_NOW(a_zero_pos_energy, clk, rst_n, out_valid && out_peak_position == 10'd0, out_peak_energy == 37'd0)

endmodule

bind curve_peak_baseline_quantifier cpbq_checker u_cpbq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_peak_number   (out_ch.peak_number),
  .out_peak_position (out_ch.peak_position),
  .out_peak_energy   (out_ch.peak_energy),
  .out_last_result   (out_ch.last_result)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of curve_peak_baseline_quantifier: drives sample items,
// predicts the six peak results per curve and checks them. Uses cpbq_pkg, cpbq_if.sv.
module tb;
  import cpbq_pkg::*;

  // Expected result of one peak, field by field as the result channel carries it
  typedef struct packed {
    logic [2:0]  num;
    logic [9:0]  pos;
    logic [18:0] height;
    logic [36:0] energy;
    logic [9:0]  bpos;
    logic [26:0] blevel;
    logic        last;
  } peak_rec_t;

  typedef struct packed {
    logic [18:0] sample;
    logic        last;
  } sample_item_t;

  typedef struct packed {
    cfg_reg_e    idx;
    logic [59:0] data;
  } reg_write_t;

  logic clk;
  logic rst_n;

  cpbq_in_if  in_ch ();
  cpbq_out_if out_ch ();
  cpbq_cfg_if cfg_ch ();

  curve_peak_baseline_quantifier i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
  end
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the block: sample store, load pointer, registers
  // ---------------------------------------------------------------------
  logic [18:0]     curve_mem [CURVE_LENGTH];
  int unsigned     fill_cnt;
  cfg_t            shadow_cfg;
  int unsigned     base_idx;
  longint unsigned base_lvl;

  peak_rec_t    peak_expect_q [$];
  sample_item_t sample_q [$];
  reg_write_t   reg_write_q [$];

  int err_cnt;
  int curves_done;
  int samples_sent;
  int results_checked;
  bit idle_on;   // cleared for stretches with no gaps or stalls

  function automatic logic [18:0] rd(int i);
    if (i < 0 || i >= CURVE_LENGTH) return '0;
    return curve_mem[i];
  endfunction

  function automatic bit edge_ok(int p);
    return p > LOW_EDGE && p < HIGH_EDGE;
  endfunction

  function automatic int lo_lim(int v);
    return v < LOW_EDGE ? LOW_EDGE : v;
  endfunction

  function automatic int hi_lim(int v);
    return v > HIGH_EDGE ? HIGH_EDGE : v;
  endfunction

  // Mean of [lo, hi) with 8 fraction bits, floor; empty window gives 0
  function automatic longint unsigned mean_level(int lo, int hi);
    longint unsigned sum;
    longint unsigned cnt;
    sum = 0;
    cnt = 0;
    for (int i = lo; i < hi; i++) begin
      sum += rd(i);
      cnt++;
    end
    if (cnt == 0) return 0;
    return (sum << 8) / cnt;
  endfunction

  function automatic longint unsigned above_level(int i);
    longint unsigned v;
    v = longint'(rd(i)) << 8;
    return v > base_lvl ? v - base_lvl : 0;
  endfunction

  function automatic void find_base_level();
    int a;
    int b;
    int m;
    int half;
    a = shadow_cfg.base_start;
    b = shadow_cfg.base_stop;
    half = shadow_cfg.base_window / 2;
    if (!shadow_cfg.baseline_mode) begin
      base_idx = a;
      base_lvl = edge_ok(a) ? mean_level(lo_lim(a), hi_lim(a + shadow_cfg.base_window)) : 0;
    end else begin
      if (a > b) begin
        m = a;
        a = b;
        b = m;
      end
      m = 0;
      if (a > LOW_EDGE && b < HIGH_EDGE) begin
        m = a;
        // keep the first minimum
        for (int i = a; i <= b; i++)
          if (rd(i) < rd(m)) m = i;
      end
      base_idx = m;
      base_lvl = edge_ok(m) ? mean_level(lo_lim(m - half), hi_lim(m + half)) : 0;
    end
  endfunction

  function automatic int peak_index(int p);
    int half;
    int lo;
    int hi;
    int best;
    if (!edge_ok(p)) return 0;
    half = shadow_cfg.search_window / 2;
    lo = lo_lim(p - half);
    hi = hi_lim(p + half);
    best = lo;
    for (int i = lo; i < hi; i++)
      if (rd(i) > rd(best)) best = i;
    return best;
  endfunction

  function automatic longint unsigned peak_energy_of(bit height_mode, int x);
    longint unsigned e;
    int half;
    e = 0;
    if (!edge_ok(x)) return 0;
    if (height_mode) begin
      e = above_level(x);
      if (e == 0) e = 256;
    end else begin
      half = shadow_cfg.integrate_window / 2;
      for (int i = lo_lim(x - half); i < hi_lim(x + half); i++)
        e += above_level(i);
      if (e == 0) e = 2560;
    end
    return e;
  endfunction

  // Analyze the stored curve and queue the six peak results
  function automatic void analyze_curve();
    peak_rec_t r;
    int nom;
    find_base_level();
    for (int k = 0; k < NUM_PEAKS; k++) begin
      r = '0;
      r.num = k;
      if (shadow_cfg.peak_modes[k]) begin
        nom = int'(shadow_cfg.peak_positions[10*k +: 10]);
        r.pos = peak_index(nom);
        r.height = rd(int'(r.pos));
        r.energy = peak_energy_of(shadow_cfg.peak_modes[6+k], int'(r.pos));
      end
      r.bpos = base_idx;
      r.blevel = base_lvl[26:0];
      r.last = (k == NUM_PEAKS - 1);
      peak_expect_q.push_back(r);
    end
  endfunction

  function automatic void take_sample(sample_item_t it);
    if (fill_cnt < CURVE_LENGTH) begin
      curve_mem[fill_cnt] = it.sample;
      fill_cnt++;
    end
    if (it.last) begin
      fill_cnt = 0;
      curves_done++;
      analyze_curve();
    end
  endfunction

  function automatic void apply_reg(reg_write_t w);
    case (w.idx)
      REG_BASELINE_MODE:    shadow_cfg.baseline_mode = w.data[0];
      REG_BASE_START:       shadow_cfg.base_start = w.data[9:0];
      REG_BASE_STOP:        shadow_cfg.base_stop = w.data[9:0];
      REG_BASE_WINDOW:      shadow_cfg.base_window = w.data[9:0];
      REG_SEARCH_WINDOW:    shadow_cfg.search_window = w.data[9:0];
      REG_INTEGRATE_WINDOW: shadow_cfg.integrate_window = w.data[9:0];
      REG_PEAK_POSITIONS:   shadow_cfg.peak_positions = w.data;
      REG_PEAK_MODES:       shadow_cfg.peak_modes = w.data[11:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------
  // Sample driver: hold each item until accepted, random gap after each item
  // ---------------------------------------------------------------------
  sample_item_t in_cur;
  int           in_gap;
  logic         in_busy;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_busy = 1'b0;
      in_gap = 0;
    end else begin
      if (in_busy && in_ch.ready) begin
        take_sample(in_cur);
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_cur = sample_q.pop_front();
          in_busy = 1'b1;
          in_ch.valid <= 1'b1;
          in_ch.sample <= in_cur.sample;
          in_ch.last_sample <= in_cur.last;
          in_gap = idle_on ? $urandom_range(0, 9) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Register write driver
  // ---------------------------------------------------------------------
  reg_write_t cfg_cur;
  logic       cfg_busy;

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
      cfg_busy = 1'b0;
    end else begin
      if (cfg_busy && cfg_ch.ready) begin
        apply_reg(cfg_cur);
        cfg_busy = 1'b0;
      end
      if (!cfg_busy && reg_write_q.size() > 0) begin
        cfg_cur = reg_write_q.pop_front();
        cfg_busy = 1'b1;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= cfg_cur.idx;
        cfg_ch.data <= cfg_cur.data;
      end else if (!cfg_busy) begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: random stall after each item, compare with oldest expectation
  // ---------------------------------------------------------------------
  int        out_stall;
  peak_rec_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (peak_expect_q.size() == 0) begin
          report_mismatch("unexpected result, peak", out_ch.peak_number, 0);
        end else begin
          want = peak_expect_q.pop_front();
          if (out_ch.peak_number !== want.num)
            report_mismatch("peak_number", out_ch.peak_number, want.num);
          if (out_ch.peak_position !== want.pos)
            report_mismatch("peak_position", out_ch.peak_position, want.pos);
          if (out_ch.peak_height !== want.height)
            report_mismatch("peak_height", out_ch.peak_height, want.height);
          if (out_ch.peak_energy !== want.energy)
            report_mismatch("peak_energy", out_ch.peak_energy, want.energy);
          if (out_ch.base_position !== want.bpos)
            report_mismatch("base_position", out_ch.base_position, want.bpos);
          if (out_ch.base_level !== want.blevel)
            report_mismatch("base_level", out_ch.base_level, want.blevel);
          if (out_ch.last_result !== want.last)
            report_mismatch("last_result", out_ch.last_result, want.last);
        end
        out_stall = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Write every register; the block is idle whenever this is called
  task automatic program_regs(cfg_t c);
    reg_write_q.push_back({REG_BASELINE_MODE, 60'(c.baseline_mode)});
    reg_write_q.push_back({REG_BASE_START, 60'(c.base_start)});
    reg_write_q.push_back({REG_BASE_STOP, 60'(c.base_stop)});
    reg_write_q.push_back({REG_BASE_WINDOW, 60'(c.base_window)});
    reg_write_q.push_back({REG_SEARCH_WINDOW, 60'(c.search_window)});
    reg_write_q.push_back({REG_INTEGRATE_WINDOW, 60'(c.integrate_window)});
    reg_write_q.push_back({REG_PEAK_POSITIONS, c.peak_positions});
    reg_write_q.push_back({REG_PEAK_MODES, 60'(c.peak_modes)});
    while (reg_write_q.size() > 0 || cfg_busy) @(posedge clk);
  endtask

  // Send one curve of n items, the last one marked; then drain all results.
  // A flat plateau of 1000 in entries 24..255 is kept for the zero-energy defaults.
  task automatic send_curve(int n, bit plateau);
    sample_item_t it;
    for (int i = 0; i < n; i++) begin
      it.sample = $urandom_range(0, 19'h7FFFF);
      if (plateau && i >= 24 && i < 256) it.sample = 19'd1000;
      it.last = (i == n - 1);
      sample_q.push_back(it);
    end
    samples_sent += n;
    while (sample_q.size() > 0 || in_busy) @(posedge clk);
    while (peak_expect_q.size() > 0) @(posedge clk);
    // let the analysis wind down before touching registers again
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [9:0] rand_pos();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1023);
      1:       return $urandom_range(0, 12);
      2:       return $urandom_range(1010, 1023);
      3:       return $urandom_range(24, 250);
      default: return $urandom_range(9, 1015);
    endcase
  endfunction

  // Mostly narrow windows keep the analysis short; wide ones now and then
  function automatic logic [9:0] rand_win();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, 40);
  endfunction

  cfg_t c;
  int   random_items;
  int   n;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_BASELINE_MODE;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    err_cnt = 0;
    curves_done = 0;
    samples_sent = 0;
    results_checked = 0;
    idle_on = 1'b1;
    fill_cnt = 0;
    base_idx = 0;
    base_lvl = 0;
    shadow_cfg = '0;
    foreach (curve_mem[i]) curve_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole store first, past its length, so no entry is ever read unwritten;
    // reset registers: no peak in use, start position 0 is invalid
    send_curve(CURVE_LENGTH + 6, 1'b1);

    // Plateau region: baseline equals the peaks, so both zero-energy defaults show up
    c = '0;
    c.base_start = 30;
    c.base_window = 100;
    c.search_window = 20;
    c.integrate_window = 20;
    c.peak_positions = {10'd200, 10'd170, 10'd140, 10'd110, 10'd80, 10'd50};
    c.peak_modes = 12'b111000_111111;
    program_regs(c);
    send_curve(3, 1'b0);

    // Average window clipped at the high edge; peaks at invalid and edge positions
    c.base_start = 1015;
    c.base_window = 1023;
    c.search_window = 1023;
    c.integrate_window = 1023;
    c.peak_positions = {10'd1023, 10'd1016, 10'd1015, 10'd9, 10'd8, 10'd0};
    c.peak_modes = 12'b010101_111111;
    program_regs(c);
    send_curve(2, 1'b0);

    // Minimum search with reversed bounds, empty baseline window
    c.baseline_mode = 1'b1;
    c.base_start = 600;
    c.base_stop = 20;
    c.base_window = 0;
    c.search_window = 1;
    c.integrate_window = 0;
    c.peak_positions = {10'd500, 10'd400, 10'd300, 10'd250, 10'd100, 10'd20};
    c.peak_modes = 12'b101010_110011;
    program_regs(c);
    send_curve(4, 1'b0);

    // Minimum search with a bound on the low edge gives baseline 0
    c.base_start = 8;
    c.base_stop = 200;
    c.base_window = 64;
    program_regs(c);
    send_curve(1, 1'b0);

    // All registers at their maximum
    c = '1;
    program_regs(c);
    send_curve(2, 1'b0);

    // Random curves until the item budget is spent
    random_items = 0;
    while (random_items < 380) begin
      idle_on = ($urandom_range(0, 4) != 0);
      c.baseline_mode = $urandom_range(0, 1);
      c.base_start = rand_pos();
      c.base_stop = rand_pos();
      c.base_window = rand_win();
      c.search_window = rand_win();
      c.integrate_window = rand_win();
      for (int k = 0; k < NUM_PEAKS; k++) c.peak_positions[10*k +: 10] = rand_pos();
      c.peak_modes = $urandom_range(0, 4095);
      program_regs(c);
      n = $urandom_range(1, 24);
      send_curve(n, 1'b0);
      random_items += n;
    end

    $display("Covered %0d curves from %0d sample items; %0d peak results compared.",
             curves_done, samples_sent, results_checked);
    if (err_cnt == 0) begin
      $display("** curve_peak_baseline_quantifier: PASSED **");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("** curve_peak_baseline_quantifier: FAILED **");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #20000000;
    $display("Timeout: %0d results still expected", peak_expect_q.size());
    $display("** curve_peak_baseline_quantifier: FAILED **");
    $finish;
  end

endmodule
